>>> rtl/core/rtb_pkg.sv
// Shared types and constants for the repeating timer bank.
// Used by every module under rtl/core except rtb_ram; depends on nothing else.
`default_nettype none

package rtb_pkg;

	localparam int NUM_TIMERS  = 16;
	localparam int SPLIT_INDEX = 8;

	// Timer RAM address and sweep pointer widths
	localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int PW = $clog2(NUM_TIMERS + 1);

	localparam int SPLIT_CLAMP = (SPLIT_INDEX < NUM_TIMERS) ? SPLIT_INDEX : NUM_TIMERS;

	// Main ticks sweep [0, MAIN_HI), aux ticks sweep [AUX_LO, NUM_TIMERS)
	localparam logic [PW-1:0] MAIN_HI = PW'(SPLIT_CLAMP);
	localparam logic [PW-1:0] AUX_LO  = PW'(SPLIT_CLAMP);
	localparam logic [PW-1:0] BANK_HI = PW'(NUM_TIMERS);

	localparam int REQ_W    = 3;
	localparam int INDEX_W  = 4;
	localparam int PERIOD_W = 16;
	localparam int BUDGET_W = 8;
	localparam int VALUE_W  = 32;

	typedef enum logic [REQ_W-1:0] {
		REQ_MAIN_TICK      = 3'd0,
		REQ_AUX_TICK       = 3'd1,
		REQ_SET_TIMER      = 3'd2,
		REQ_CHECK          = 3'd3,
		REQ_SET_GRAN       = 3'd4,
		REQ_READ_ELAPSED   = 3'd5,
		REQ_READ_REMAINING = 3'd6,
		REQ_READ_TICKS     = 3'd7
	} req_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_UPDATE,
		ST_REPLY
	} state_t;

	typedef struct packed {
		logic [BUDGET_W-1:0] budget;
		logic [PERIOD_W-1:0] reload;
		logic [PERIOD_W-1:0] remaining;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic   we;
		entry_t wdata;
		logic   expired;
	} upd_t;

endpackage

`default_nettype wire

>>> rtl/core/repeating_timer_bank_top.sv
// Repeating timer bank: sequencer, timer entry RAM with valid bits, shared entry unit.
// Depends on rtb_pkg, rtb_ram, rtb_entry_alu and rtb_elapsed.
//
//   channel   | handshake            | signals
//   ----------+----------------------+------------------------------------------------
//   request   | start & !busy        | req_type timer_index period_ticks
//             |                      | repeat_budget elapsed_select
//   result    | done (one cycle)     | expired read_value
//
// A tick request sweeps its timers one entry at a time through the single RAM read
// port and the shared entry unit, each entry in a fetch step and then an update step;
// the reply follows the last entry. Every other request passes once through fetch,
// update and reply.
// Reset clears all timers at once through per-entry valid bits; no clearing pass.
// busy stays high from the transfer until the cycle after done; results cannot stall.
`default_nettype none

module repeating_timer_bank_top (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             start,
	input  wire logic [rtb_pkg::REQ_W-1:0]        req_type,
	input  wire logic [rtb_pkg::INDEX_W-1:0]      timer_index,
	input  wire logic [rtb_pkg::PERIOD_W-1:0]     period_ticks,
	input  wire logic [rtb_pkg::BUDGET_W-1:0]     repeat_budget,
	input  wire logic                             elapsed_select,
	output      logic                             busy,
	output      logic                             done,
	output      logic                             expired,
	output      logic [rtb_pkg::VALUE_W-1:0]      read_value
);

	rtb_pkg::state_t state_q, state_d;
	rtb_pkg::req_t   req_q;
	rtb_pkg::req_t   req_in;

	logic [rtb_pkg::PW-1:0]         ptr_q;
	logic [rtb_pkg::PW-1:0]         ptr_start;
	logic [rtb_pkg::PW-1:0]         sweep_hi;
	logic [rtb_pkg::PW:0]           ptr_next;
	logic [rtb_pkg::AW-1:0]         addr;
	logic [rtb_pkg::PERIOD_W-1:0]   period_q;
	logic [rtb_pkg::BUDGET_W-1:0]   bud_q;
	logic                           sel_q;
	logic                           idx_ok_q;
	logic                           expired_q;
	logic [rtb_pkg::VALUE_W-1:0]    value_q;
	logic [rtb_pkg::NUM_TIMERS-1:0] valid_q;

	logic                           accept;
	logic                           is_sweep;
	logic                           is_index_op;
	logic                           entry_ok;
	logic                           more;
	logic                           ram_re;
	logic                           upd_active;
	logic [rtb_pkg::ENTRY_W-1:0]    ram_rdata;
	rtb_pkg::entry_t                entry;
	rtb_pkg::upd_t                  upd;
	logic [rtb_pkg::VALUE_W-1:0]    tick_total;
	logic [rtb_pkg::PERIOD_W-1:0]   count_sel;
	logic                           tick_pulse;
	logic                           gran_pulse;

	assign req_in = rtb_pkg::req_t'(req_type);
	assign accept = start && !busy;

	assign is_sweep    = (req_q == rtb_pkg::REQ_MAIN_TICK) || (req_q == rtb_pkg::REQ_AUX_TICK);
	assign is_index_op = (req_q == rtb_pkg::REQ_SET_TIMER) || (req_q == rtb_pkg::REQ_CHECK) ||
	                     (req_q == rtb_pkg::REQ_READ_REMAINING);
	assign sweep_hi    = (req_q == rtb_pkg::REQ_MAIN_TICK) ? rtb_pkg::MAIN_HI : rtb_pkg::BANK_HI;
	assign ptr_next    = {1'b0, ptr_q} + 1'b1;
	assign more        = is_sweep && (ptr_next < {1'b0, sweep_hi});
	assign addr        = ptr_q[rtb_pkg::AW-1:0];

	// An aux sweep with the split at the bank end touches nothing
	assign entry_ok   = is_sweep ? (ptr_q < sweep_hi) : (is_index_op && idx_ok_q);
	assign upd_active = (state_q == rtb_pkg::ST_UPDATE) && entry_ok;

	always_comb begin
		unique case (req_in)
			rtb_pkg::REQ_MAIN_TICK: ptr_start = '0;
			rtb_pkg::REQ_AUX_TICK:  ptr_start = rtb_pkg::AUX_LO;
			default:                ptr_start = rtb_pkg::PW'(timer_index);
		endcase
	end

	// Entries never written since reset read as zero count and zero budget
	always_comb begin
		entry = rtb_pkg::entry_t'(ram_rdata);
		if (!(entry_ok && valid_q[addr])) begin
			entry.remaining = '0;
			entry.budget    = '0;
		end
	end

	rtb_ram #(
		.WIDTH (rtb_pkg::ENTRY_W),
		.DEPTH (rtb_pkg::NUM_TIMERS)
	) u_ram (
		.clk   (clk),
		.we    (upd.we),
		.waddr (addr),
		.wdata (upd.wdata),
		.re    (ram_re),
		.raddr (addr),
		.rdata (ram_rdata)
	);

	rtb_entry_alu u_alu (
		.active (upd_active),
		.op     (req_q),
		.entry  (entry),
		.period (period_q),
		.bud    (bud_q),
		.upd    (upd)
	);

	rtb_elapsed u_elapsed (
		.clk        (clk),
		.arst_n     (arst_n),
		.tick       (tick_pulse),
		.set_gran   (gran_pulse),
		.sel        (sel_q),
		.period     (period_q),
		.tick_total (tick_total),
		.count_sel  (count_sel)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rtb_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		ram_re     = 1'b0;
		busy       = 1'b1;
		done       = 1'b0;
		tick_pulse = 1'b0;
		gran_pulse = 1'b0;
		unique case (state_q)
			rtb_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					state_d = rtb_pkg::ST_FETCH;
				end
			end
			rtb_pkg::ST_FETCH: begin
				ram_re  = 1'b1;
				state_d = rtb_pkg::ST_UPDATE;
			end
			rtb_pkg::ST_UPDATE: begin
				state_d = (more && entry_ok) ? rtb_pkg::ST_FETCH : rtb_pkg::ST_REPLY;
			end
			rtb_pkg::ST_REPLY: begin
				done       = 1'b1;
				tick_pulse = (req_q == rtb_pkg::REQ_MAIN_TICK);
				gran_pulse = (req_q == rtb_pkg::REQ_SET_GRAN);
				state_d    = rtb_pkg::ST_IDLE;
			end
			default: begin
				state_d = rtb_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (upd.we) begin
			valid_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q     <= req_in;
			ptr_q     <= ptr_start;
			period_q  <= period_ticks;
			bud_q     <= repeat_budget;
			sel_q     <= elapsed_select;
			idx_ok_q  <= (8'(timer_index) < 8'(rtb_pkg::NUM_TIMERS));
			expired_q <= 1'b0;
			value_q   <= '0;
		end else if (state_q == rtb_pkg::ST_UPDATE) begin
			if (more) begin
				ptr_q <= ptr_next[rtb_pkg::PW-1:0];
			end
			if (upd.expired) begin
				expired_q <= 1'b1;
			end
			unique case (req_q)
				rtb_pkg::REQ_READ_ELAPSED:   value_q <= 32'(count_sel);
				rtb_pkg::REQ_READ_REMAINING: value_q <= 32'(entry.remaining);
				rtb_pkg::REQ_READ_TICKS:     value_q <= tick_total;
				default:                     value_q <= '0;
			endcase
		end
	end

	assign expired    = expired_q;
	assign read_value = value_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("request transfer did not start a sequence");

	a_write_in_update: assert property (@(posedge clk) disable iff (!arst_n)
		upd.we |-> (state_q == rtb_pkg::ST_UPDATE) && entry_ok)
		else $error("timer RAM written outside an update step");

	a_expired_on_check: assert property (@(posedge clk) disable iff (!arst_n)
		(done && expired) |-> (req_q == rtb_pkg::REQ_CHECK))
		else $error("expiry reported for a request that is not a check");

	a_read_only_fetch: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == rtb_pkg::ST_UPDATE) |-> $past(ram_re))
		else $error("update step without a preceding fetch");

endmodule

`default_nettype wire

>>> rtl/core/rtb_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
`default_nettype none

module rtb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/core/rtb_entry_alu.sv
// Shared timer entry unit: decrement, load, and expiry check/reload of one entry.
// Depends on rtb_pkg for req_t, entry_t and upd_t.
`default_nettype none

module rtb_entry_alu (
	input  wire logic                              active,
	input  wire rtb_pkg::req_t                     op,
	input  wire rtb_pkg::entry_t                   entry,
	input  wire logic [rtb_pkg::PERIOD_W-1:0]      period,
	input  wire logic [rtb_pkg::BUDGET_W-1:0]      bud,
	output      rtb_pkg::upd_t                     upd
);

	logic rem_zero;
	logic bud_zero;

	assign rem_zero = (entry.remaining == '0);
	assign bud_zero = (entry.budget == '0);

	always_comb begin
		upd       = '0;
		upd.wdata = entry;
		unique case (op)
			rtb_pkg::REQ_MAIN_TICK, rtb_pkg::REQ_AUX_TICK: begin
				if (!rem_zero) begin
					upd.we              = active;
					upd.wdata.remaining = entry.remaining - 16'd1;
				end
			end
			rtb_pkg::REQ_SET_TIMER: begin
				upd.we              = active;
				upd.wdata.budget    = bud;
				upd.wdata.reload    = period;
				upd.wdata.remaining = period;
			end
			rtb_pkg::REQ_CHECK: begin
				if (rem_zero && !bud_zero) begin
					upd.we              = active;
					upd.expired         = active;
					upd.wdata.remaining = entry.reload;
					upd.wdata.budget    = entry.budget - 8'd1;
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/core/rtb_elapsed.sv
// Running count of main ticks and the two prescaled elapsed counters.
// Depends on rtb_pkg for field widths.
`default_nettype none

module rtb_elapsed (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          tick,
	input  wire logic                          set_gran,
	input  wire logic                          sel,
	input  wire logic [rtb_pkg::PERIOD_W-1:0]  period,
	output      logic [rtb_pkg::VALUE_W-1:0]   tick_total,
	output      logic [rtb_pkg::PERIOD_W-1:0]  count_sel
);

	logic [rtb_pkg::VALUE_W-1:0]  ticks_q;
	logic [rtb_pkg::PERIOD_W-1:0] pre_q   [2];
	logic [rtb_pkg::PERIOD_W-1:0] count_q [2];
	logic [rtb_pkg::PERIOD_W-1:0] gran_q  [2];
	logic [rtb_pkg::PERIOD_W-1:0] pre_inc [2];
	logic                         hit     [2];

	always_comb begin
		for (int s = 0; s < 2; s++) begin
			pre_inc[s] = pre_q[s] + 16'd1;
			hit[s]     = (pre_inc[s] == gran_q[s]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			for (int s = 0; s < 2; s++) begin
				pre_q[s]   <= '0;
				count_q[s] <= '0;
				gran_q[s]  <= '0;
			end
		end else begin
			if (tick) begin
				ticks_q <= ticks_q + 32'd1;
			end
			for (int s = 0; s < 2; s++) begin
				if (set_gran && (sel == 1'(s))) begin
					gran_q[s]  <= period;
					count_q[s] <= '0;
					pre_q[s]   <= '0;
				end else if (tick) begin
					// Roll the count when the prescaler reaches the granularity
					if (hit[s]) begin
						count_q[s] <= count_q[s] + 16'd1;
						pre_q[s]   <= '0;
					end else begin
						pre_q[s] <= pre_inc[s];
					end
				end
			end
		end
	end

	assign tick_total = ticks_q;
	assign count_sel  = count_q[sel];

endmodule

`default_nettype wire

>>> tb/repeating_timer_bank_top_test.sv
// Self-checking testbench for repeating_timer_bank_top: directed table, then weighted random requests.
// Depends on rtb_pkg and the RTL under rtl/core; a behavioral timer bank in here predicts each untyped reply.
`default_nettype none

module repeating_timer_bank_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rtb_pkg::*;

	localparam int RANDOM_ITEMS  = 400;
	localparam int STALL_LIMIT   = 500;
	localparam int SETTLE_CYCLES = 40;
	localparam int IDLE_PERCENT  = 19;

	typedef struct packed {
		logic                expired;
		logic [VALUE_W-1:0]  value;
	} reply_t;

	typedef struct packed {
		req_t                 req;
		logic [INDEX_W-1:0]   idx;
		logic [PERIOD_W-1:0]  period;
		logic [BUDGET_W-1:0]  bud;
		logic                 sel;
		bit                   typed;
		logic                 exp_expired;
		logic [VALUE_W-1:0]   exp_value;
	} stim_row_t;

	localparam int DIRECTED_ROWS = 26;

	localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
		'{REQ_READ_TICKS,     4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_REMAINING, 4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_REMAINING, 4'd15, 16'hFFFF, 8'hFF,  1'b1, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_ELAPSED,   4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_ELAPSED,   4'd0,  16'h0000, 8'd0,   1'b1, 1'b1, 1'b0, 32'd0},
		// never set: zero budget means no expiry and no reload read
		'{REQ_CHECK,          4'd5,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_SET_TIMER,      4'd0,  16'h0000, 8'd255, 1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_CHECK,          4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b1, 32'd0},
		'{REQ_READ_REMAINING, 4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_SET_TIMER,      4'd15, 16'hFFFF, 8'd1,   1'b1, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_REMAINING, 4'd15, 16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'h0000FFFF},
		'{REQ_SET_GRAN,       4'd0,  16'd2,    8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_SET_GRAN,       4'd0,  16'hFFFF, 8'd0,   1'b1, 1'b1, 1'b0, 32'd0},
		'{REQ_MAIN_TICK,      4'd3,  16'h1234, 8'd7,   1'b1, 1'b1, 1'b0, 32'd0},
		'{REQ_MAIN_TICK,      4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_ELAPSED,   4'd0,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, 32'd0},
		'{REQ_READ_TICKS,     4'd9,  16'hFFFF, 8'hFF,  1'b1, 1'b1, 1'b0, 32'd2},
		'{REQ_AUX_TICK,       4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_READ_REMAINING, 4'd15, 16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, 32'd0},
		'{REQ_SET_TIMER,      4'd7,  16'd1,    8'd2,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_MAIN_TICK,      4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_CHECK,          4'd7,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, 32'd0},
		'{REQ_CHECK,          4'd7,  16'h0000, 8'd0,   1'b0, 1'b0, 1'b0, 32'd0},
		'{REQ_SET_TIMER,      4'd8,  16'd1,    8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_AUX_TICK,       4'd0,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0},
		'{REQ_CHECK,          4'd8,  16'h0000, 8'd0,   1'b0, 1'b1, 1'b0, 32'd0}
	};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic [REQ_W-1:0]     req_type;
	logic [INDEX_W-1:0]   timer_index;
	logic [PERIOD_W-1:0]  period_ticks;
	logic [BUDGET_W-1:0]  repeat_budget;
	logic                 elapsed_select;
	logic                 busy;
	logic                 done;
	logic                 expired;
	logic [VALUE_W-1:0]   read_value;

	repeating_timer_bank_top DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.req_type       (req_type),
		.timer_index    (timer_index),
		.period_ticks   (period_ticks),
		.repeat_budget  (repeat_budget),
		.elapsed_select (elapsed_select),
		.busy           (busy),
		.done           (done),
		.expired        (expired),
		.read_value     (read_value)
	);

	// predicted bank state
	logic [PERIOD_W-1:0]  rem_cnt    [NUM_TIMERS];
	logic [PERIOD_W-1:0]  reload_val [NUM_TIMERS];
	logic [BUDGET_W-1:0]  bud_left   [NUM_TIMERS];
	logic [VALUE_W-1:0]   tick_cnt;
	logic [15:0]          prescale   [2];
	logic [15:0]          ecount     [2];
	logic [15:0]          gran       [2];

	reply_t  pending_replies [$];
	int      fail_count;
	int      items_sent;
	int      results_seen;
	int      expiries_seen;
	int      main_ticks;
	int      stall_cycles;
	bit      no_idle;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void sweep_timers(input int lo, input int hi);
		int i;
		for (i = lo; i < hi && i < NUM_TIMERS; i++)
			if (rem_cnt[i] != '0)
				rem_cnt[i] = rem_cnt[i] - 1'b1;
	endfunction

	function automatic reply_t bank_step(input req_t req, input logic [INDEX_W-1:0] idx,
			input logic [PERIOD_W-1:0] period, input logic [BUDGET_W-1:0] bud, input logic sel);
		reply_t r;
		bit     in_bank;
		int     s;
		r       = '0;
		in_bank = int'(idx) < NUM_TIMERS;
		case (req)
			REQ_MAIN_TICK: begin
				tick_cnt = tick_cnt + 1'b1;
				main_ticks++;
				sweep_timers(0, SPLIT_INDEX);
				for (s = 0; s < 2; s++) begin
					prescale[s] = prescale[s] + 1'b1;
					if (prescale[s] == gran[s]) begin
						ecount[s]   = ecount[s] + 1'b1;
						prescale[s] = '0;
					end
				end
			end
			REQ_AUX_TICK: sweep_timers(SPLIT_INDEX, NUM_TIMERS);
			REQ_SET_TIMER: begin
				if (in_bank) begin
					rem_cnt[idx]    = period;
					reload_val[idx] = period;
					bud_left[idx]   = bud;
				end
			end
			REQ_CHECK: begin
				if (in_bank && rem_cnt[idx] == '0 && bud_left[idx] != '0) begin
					rem_cnt[idx]  = reload_val[idx];
					bud_left[idx] = bud_left[idx] - 1'b1;
					r.expired     = 1'b1;
					expiries_seen++;
				end
			end
			REQ_SET_GRAN: begin
				gran[sel]     = period;
				ecount[sel]   = '0;
				prescale[sel] = '0;
			end
			REQ_READ_ELAPSED: r.value = VALUE_W'(ecount[sel]);
			REQ_READ_REMAINING: begin
				if (in_bank)
					r.value = VALUE_W'(rem_cnt[idx]);
			end
			default: r.value = tick_cnt;
		endcase
		return r;
	endfunction

	// hold the request until the transfer, then record what it should return
	task automatic send_item(input req_t req, input logic [INDEX_W-1:0] idx,
			input logic [PERIOD_W-1:0] period, input logic [BUDGET_W-1:0] bud, input logic sel,
			input bit typed, input reply_t typed_reply);
		reply_t predicted;
		req_type       <= req;
		timer_index    <= idx;
		period_ticks   <= period;
		repeat_budget  <= bud;
		elapsed_select <= sel;
		start          <= 1'b1;
		do @(posedge clk); while (busy);
		predicted = bank_step(req, idx, period, bud, sel);
		pending_replies.push_back(typed ? typed_reply : predicted);
		items_sent++;
	endtask

	task automatic sender_gap();
		int cycles;
		cycles = 0;
		if (!no_idle && $urandom_range(99) < IDLE_PERCENT)
			cycles = $urandom_range(1, 6);
		if (cycles > 0) begin
			start <= 1'b0;
			repeat (cycles) @(posedge clk);
		end
	endtask

	task automatic drain_replies();
		start <= 1'b0;
		do @(posedge clk); while (pending_replies.size() != 0);
	endtask

	always @(posedge clk) begin : result_check
		reply_t want;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				fail_count++;
				if (fail_count <= 10)
					$display("%0t: result with nothing pending: expired=%0b value=%h",
						$realtime, expired, read_value);
			end else begin
				want = pending_replies.pop_front();
				results_seen++;
				if (expired !== want.expired || read_value !== want.value) begin
					fail_count++;
					if (fail_count <= 10)
						$display("%0t: mismatch: expired exp %0b got %0b, value exp %h got %h",
							$realtime, want.expired, expired, want.value, read_value);
				end
			end
		end
	end

	// count cycles with neither a request transfer nor a result
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done)
			stall_cycles = 0;
		else begin
			stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: no transfer for %0d cycles, %0d replies pending",
					$realtime, stall_cycles, pending_replies.size());
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int                   n;
		int                   pick;
		req_t                 req;
		logic [INDEX_W-1:0]   idx;
		logic [PERIOD_W-1:0]  period;
		logic [BUDGET_W-1:0]  bud;
		logic                 sel;
		reply_t               typed_reply;

		for (n = 0; n < NUM_TIMERS; n++) begin
			rem_cnt[n]    = '0;
			reload_val[n] = '0;
			bud_left[n]   = '0;
		end
		for (n = 0; n < 2; n++) begin
			prescale[n] = '0;
			ecount[n]   = '0;
			gran[n]     = '0;
		end
		tick_cnt      = '0;
		fail_count    = 0;
		items_sent    = 0;
		results_seen  = 0;
		expiries_seen = 0;
		main_ticks    = 0;
		stall_cycles  = 0;
		no_idle       = 1'b0;

		arst_n         <= 1'b0;
		start          <= 1'b0;
		req_type       <= REQ_MAIN_TICK;
		timer_index    <= '0;
		period_ticks   <= '0;
		repeat_budget  <= '0;
		elapsed_select <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < DIRECTED_ROWS; n++) begin
			typed_reply.expired = DIRECTED[n].exp_expired;
			typed_reply.value   = DIRECTED[n].exp_value;
			send_item(DIRECTED[n].req, DIRECTED[n].idx, DIRECTED[n].period, DIRECTED[n].bud,
				DIRECTED[n].sel, DIRECTED[n].typed, typed_reply);
			sender_gap();
		end
		drain_replies();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			no_idle = (n >= 150 && n < 250);
			pick    = $urandom_range(99);
			idx     = INDEX_W'($urandom_range(NUM_TIMERS - 1));
			period  = PERIOD_W'($urandom);
			bud     = BUDGET_W'($urandom);
			sel     = 1'($urandom_range(1));
			if (pick < 25)
				req = REQ_MAIN_TICK;
			else if (pick < 40)
				req = REQ_AUX_TICK;
			else if (pick < 53) begin
				req = REQ_SET_TIMER;
				// keep most periods short so timers actually run down
				if ($urandom_range(9) < 7)
					period = PERIOD_W'($urandom_range(6));
				pick = $urandom_range(9);
				if (pick < 6)
					bud = BUDGET_W'($urandom_range(3));
				else if (pick < 8)
					bud = 8'd255;
			end else if (pick < 73)
				req = REQ_CHECK;
			else if (pick < 78) begin
				req = REQ_SET_GRAN;
				if ($urandom_range(3) != 0)
					period = PERIOD_W'($urandom_range(5));
			end else if (pick < 86)
				req = REQ_READ_ELAPSED;
			else if (pick < 96)
				req = REQ_READ_REMAINING;
			else
				req = REQ_READ_TICKS;
			send_item(req, idx, period, bud, sel, 1'b0, '0);
			if (n % 100 == 99)
				drain_replies();
			else
				sender_gap();
		end

		drain_replies();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sent %0d requests (%0d main ticks), checked %0d replies, saw %0d timer expiries.",
			items_sent, main_ticks, results_seen, expiries_seen);
		$display("Mismatches or stray replies: %0d", fail_count);
		if (fail_count == 0 && pending_replies.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

`default_nettype wire
